FILE: design/knt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the keyword/number tokenizer.
// No dependencies; used by every module in design/.
package knt_pkg;

    localparam int LINE_MAX             = 4096;
    localparam int KEYWORD_MAX_LEN_DEF  = 8;
    localparam int COL_MAX_INT          = ((LINE_MAX - 1) > 4095) ? 4095 : (LINE_MAX - 1);
    localparam logic [11:0] COL_MAX     = 12'(COL_MAX_INT);
    localparam logic [11:0] LEN_MAX     = 12'hFFF;

    // keywords are compared on their first eight characters
    localparam int KW_CMP_LEN           = 8;
    localparam int KW_COUNT             = 23;

    localparam int QUEUE_DEPTH          = 4;
    localparam int TDATA_W              = 40;

    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_POINT     = 8'h2E;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;

    // keyword text, right aligned: the last character sits in the low byte
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'("int"), 64'("float"), 64'("string"), 64'("bool"), 64'("char"),
        64'("if"), 64'("elif"), 64'("else"), 64'("branch"),
        64'("public"), 64'("private"), 64'("inherit"), 64'("package"),
        64'("nosign"), 64'("const"), 64'("extended"),
        64'("do"), 64'("while"), 64'("for"), 64'("repeat"),
        64'("in"), 64'("struct"), 64'("return")
    };

    localparam int KW_LEN [KW_COUNT] = '{
        3, 5, 6, 4, 4,
        2, 4, 4, 6,
        6, 7, 7, 7,
        6, 5, 8,
        2, 5, 3, 6,
        2, 6, 6
    };

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_WORD = 2'd1,
        MODE_NUM  = 2'd2
    } scan_mode_t;

    typedef enum logic [2:0] {
        KIND_KEYWORD    = 3'd0,
        KIND_IDENTIFIER = 3'd1,
        KIND_INTEGER    = 3'd2,
        KIND_FLOAT      = 3'd3,
        KIND_OPERATOR   = 3'd4,
        KIND_PUNCT      = 3'd5,
        KIND_UNKNOWN    = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [11:0] start;
        logic [11:0] length;
        logic [7:0]  first;
        logic        last;
    } token_t;

    // tokens produced by one character, in output order
    typedef struct packed {
        logic [1:0] n;
        token_t     tok0;
        token_t     tok1;
    } push_t;

    // character i of keyword k, zero past its end
    function automatic logic [7:0] kw_byte(input int k, input int i);
        int sh;
        sh = KW_LEN[k] - 1 - i;
        if (sh < 0)
            return 8'h00;
        return 8'(KW_TEXT[k] >> (8 * sh));
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

endpackage

FILE: design/keyword_number_tokenizer_unit.sv
`timescale 1ns / 1ps
// Keyword/number tokenizer, top level: stream ports, scanner and result queue.
// Depends on knt_pkg, knt_scan, knt_out_queue.
//
// One source character is taken per cycle on the s_ stream while s_tready
// is high (tlast marks the last character of a line). Each character yields
// zero, one or two tokens, delivered one per cycle on the m_ stream while
// m_tready is high, with tlast set on the last token that character caused.
// A character passes through one input register, then a four-entry result
// queue whose head drives m_tdata. Input runs at one character per cycle as
// long as the output drains one token per cycle; characters that yield two
// tokens go out as two transfers, and the queue holds off input when fewer
// than two slots would be free. An unknown character is reported and then
// every further character is taken and dropped until reset.
module keyword_number_tokenizer_unit
#(
    parameter int KEYWORD_MAX_LEN = knt_pkg::KEYWORD_MAX_LEN_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] ch
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [2:0] token_kind, [14:3] start_column, [26:15] token_length,
    // [34:27] first_char, [39:35] zero
    output logic [knt_pkg::TDATA_W-1:0] m_tdata,
    output logic                        m_tlast
);

    knt_pkg::push_t  push;
    knt_pkg::token_t head;
    logic            room;
    logic            halted;

    knt_scan
    #(
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
    )
    u_scan
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_ch    (s_tdata),
        .in_le    (s_tlast),
        .room     (room),
        .push     (push),
        .halted   (halted)
    );

    knt_out_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (head)
    );

    assign m_tdata = {5'd0, head.first, head.length, head.start, head.kind};
    assign m_tlast = head.last;

`ifndef SYNTHESIS
    a_push_max: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd3)
        else $error("scanner produced more than two tokens");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> room)
        else $error("token pushed into a full queue");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted |=> halted)
        else $error("halt cleared without reset");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        $past(halted) && halted |-> (push.n == 2'd0))
        else $error("tokens produced while halted");
`endif

endmodule

FILE: design/knt_kw_match.sv
`timescale 1ns / 1ps
// Parallel compare of a word prefix against the fixed keyword list.
// Depends on knt_pkg.
module knt_kw_match
(
    input  logic [7:0]  prefix [knt_pkg::KW_CMP_LEN],
    input  logic [11:0] count,
    output logic        match
);

    logic same;

    always_comb
    begin
        match = 1'b0;
        same  = 1'b0;
        for (int k = 0; k < knt_pkg::KW_COUNT; k++)
        begin
            same = (count == 12'(knt_pkg::KW_LEN[k]));
            for (int i = 0; i < knt_pkg::KW_CMP_LEN; i++)
            begin
                if (i < knt_pkg::KW_LEN[k])
                begin
                    if (prefix[i] != knt_pkg::kw_byte(k, i))
                        same = 1'b0;
                end
            end
            match = match | same;
        end
    end

endmodule

FILE: design/knt_scan.sv
`timescale 1ns / 1ps
// Input register and scanner: classifies one character per cycle when not stalled, keeps
// the pending word/number state, emits up to two tokens. Depends on knt_pkg, knt_kw_match.
module knt_scan
#(
    parameter int KEYWORD_MAX_LEN = knt_pkg::KEYWORD_MAX_LEN_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_ch,
    input  logic           in_le,
    input  logic           room,
    output knt_pkg::push_t push,
    output logic           halted
);

    localparam int IDX_W = $clog2(KEYWORD_MAX_LEN);

    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            ch_reg;
    logic                  le_reg;

    knt_pkg::scan_mode_t   mode_reg, mode_next;
    logic                  point_reg, point_next;
    logic [11:0]           col_reg, col_next;
    logic [11:0]           start_reg, start_next;
    logic [11:0]           count_reg, count_next;
    logic [7:0]            first_reg, first_next;
    logic                  halted_reg, halted_next;
    logic [7:0]            prefix_reg [KEYWORD_MAX_LEN];

    logic                  advance, step;
    logic                  c_alpha, c_digit, c_space, c_op, c_punct, cont;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [7:0]            pre_cur [knt_pkg::KW_CMP_LEN];
    logic [7:0]            pre_mid [knt_pkg::KW_CMP_LEN];
    logic                  match_cur, match_mid;
    logic                  f1, sg, f2;
    knt_pkg::token_t       t_f1, t_sg, t_f2;
    knt_pkg::scan_mode_t   mode_mid;
    logic                  point_mid;

    assign advance  = in_valid_reg && room;
    assign in_ready = !in_valid_reg || room;
    assign step     = advance && !halted_reg;
    assign halted   = halted_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= knt_pkg::MODE_IDLE;
            point_reg    <= 1'b0;
            col_reg      <= '0;
            start_reg    <= '0;
            count_reg    <= '0;
            first_reg    <= '0;
            halted_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            mode_reg     <= mode_next;
            point_reg    <= point_next;
            col_reg      <= col_next;
            start_reg    <= start_next;
            count_reg    <= count_next;
            first_reg    <= first_next;
            halted_reg   <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg <= in_ch;
            le_reg <= in_le;
        end
        if (step && wr_en)
            prefix_reg[wr_idx] <= ch_reg;
    end

    always_comb
    begin
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    // character classes
    always_comb
    begin
        c_alpha = knt_pkg::is_alpha(ch_reg);
        c_digit = knt_pkg::is_digit(ch_reg);
        c_space = knt_pkg::is_space(ch_reg);
        c_op    = (ch_reg == knt_pkg::CH_PLUS) || (ch_reg == knt_pkg::CH_MINUS) ||
                  (ch_reg == knt_pkg::CH_STAR) || (ch_reg == knt_pkg::CH_SLASH);
        c_punct = (ch_reg == knt_pkg::CH_LPAREN) || (ch_reg == knt_pkg::CH_RPAREN) ||
                  (ch_reg == knt_pkg::CH_LBRACE) || (ch_reg == knt_pkg::CH_RBRACE);
        cont    = ((mode_reg == knt_pkg::MODE_WORD) && (c_alpha || c_digit)) ||
                  ((mode_reg == knt_pkg::MODE_NUM) &&
                   (c_digit || ((ch_reg == knt_pkg::CH_POINT) && !point_reg)));
    end

    // prefix write: next character of a word, or the first of a new word or number
    always_comb
    begin
        wr_en  = 1'b0;
        wr_idx = '0;
        if (cont)
        begin
            wr_en  = (mode_reg == knt_pkg::MODE_WORD) &&
                     (count_reg < 12'(KEYWORD_MAX_LEN));
            wr_idx = count_reg[IDX_W-1:0];
        end
        else if (c_alpha || c_digit)
        begin
            wr_en  = 1'b1;
            wr_idx = '0;
        end
        for (int i = 0; i < knt_pkg::KW_CMP_LEN; i++)
        begin
            pre_cur[i] = prefix_reg[i];
            pre_mid[i] = (wr_en && (wr_idx == IDX_W'(i))) ? ch_reg : prefix_reg[i];
        end
    end

    knt_kw_match u_match_cur
    (
        .prefix (pre_cur),
        .count  (count_reg),
        .match  (match_cur)
    );

    knt_kw_match u_match_mid
    (
        .prefix (pre_mid),
        .count  (count_next),
        .match  (match_mid)
    );

    always_comb
    begin
        mode_mid    = mode_reg;
        point_mid   = point_reg;
        start_next  = start_reg;
        count_next  = count_reg;
        first_next  = first_reg;
        halted_next = halted_reg;
        col_next    = col_reg;

        f1 = !cont && (mode_reg != knt_pkg::MODE_IDLE);
        sg = !cont && !c_space && !c_alpha && !c_digit;

        t_f1.kind   = (mode_reg == knt_pkg::MODE_WORD) ?
                      (match_cur ? knt_pkg::KIND_KEYWORD : knt_pkg::KIND_IDENTIFIER) :
                      (point_reg ? knt_pkg::KIND_FLOAT : knt_pkg::KIND_INTEGER);
        t_f1.start  = start_reg;
        t_f1.length = count_reg;
        t_f1.first  = first_reg;
        t_f1.last   = 1'b0;

        t_sg.kind   = c_op ? knt_pkg::KIND_OPERATOR :
                      (c_punct ? knt_pkg::KIND_PUNCT : knt_pkg::KIND_UNKNOWN);
        t_sg.start  = col_reg;
        t_sg.length = 12'd1;
        t_sg.first  = ch_reg;
        t_sg.last   = 1'b0;

        if (cont)
        begin
            if (ch_reg == knt_pkg::CH_POINT)
                point_mid = 1'b1;
            if (count_reg < knt_pkg::LEN_MAX)
                count_next = count_reg + 12'd1;
        end
        else if (c_alpha || c_digit)
        begin
            mode_mid   = c_alpha ? knt_pkg::MODE_WORD : knt_pkg::MODE_NUM;
            point_mid  = 1'b0;
            start_next = col_reg;
            count_next = 12'd1;
            first_next = ch_reg;
        end
        else
        begin
            mode_mid  = knt_pkg::MODE_IDLE;
            point_mid = 1'b0;
            if (sg && !c_op && !c_punct)
                halted_next = 1'b1;
        end

        // line end flushes whatever is still open after this character
        f2 = le_reg && (mode_mid != knt_pkg::MODE_IDLE);

        mode_next  = f2 ? knt_pkg::MODE_IDLE : mode_mid;
        point_next = f2 ? 1'b0 : point_mid;

        if (le_reg)
            col_next = '0;
        else if (col_reg < knt_pkg::COL_MAX)
            col_next = col_reg + 12'd1;

        if (!step)
        begin
            mode_next   = mode_reg;
            point_next  = point_reg;
            start_next  = start_reg;
            count_next  = count_reg;
            first_next  = first_reg;
            halted_next = halted_reg;
            col_next    = col_reg;
        end
    end

    // line-end token, built from the state after this character
    always_comb
    begin
        t_f2.kind   = (mode_mid == knt_pkg::MODE_WORD) ?
                      (match_mid ? knt_pkg::KIND_KEYWORD : knt_pkg::KIND_IDENTIFIER) :
                      (point_mid ? knt_pkg::KIND_FLOAT : knt_pkg::KIND_INTEGER);
        t_f2.start  = start_next;
        t_f2.length = count_next;
        t_f2.first  = first_next;
        t_f2.last   = 1'b0;
    end

    // pack the produced tokens in order: pending flush, single, line-end flush
    always_comb
    begin
        push.tok0 = f1 ? t_f1 : (sg ? t_sg : t_f2);
        push.tok1 = f1 ? (sg ? t_sg : t_f2) : t_f2;
        push.n    = step ? (2'({1'b0, f1}) + 2'({1'b0, sg}) + 2'({1'b0, f2})) : 2'd0;
        push.tok0.last = (push.n == 2'd1);
        push.tok1.last = 1'b1;
    end

endmodule

FILE: design/knt_out_queue.sv
`timescale 1ns / 1ps
// Result queue: takes up to two tokens a cycle, presents one token a cycle
// while out_ready is high, from a fixed head register. Depends on knt_pkg.
module knt_out_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  knt_pkg::push_t  push,
    output logic            room,
    output logic            out_valid,
    input  logic            out_ready,
    output knt_pkg::token_t out_tok
);

    localparam int DEPTH = knt_pkg::QUEUE_DEPTH;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    knt_pkg::token_t  q_reg [DEPTH];
    knt_pkg::token_t  q_next [DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cnt_after;
    logic             pop;
    logic [IDX_W-1:0] idx0, idx1;

    assign out_valid = (count_reg != '0);
    assign out_tok   = q_reg[0];
    assign pop       = out_valid && out_ready;
    assign cnt_after = count_reg - CNT_W'(pop);
    // a character can yield two tokens, so keep two slots free
    assign room      = (cnt_after <= CNT_W'(DEPTH - 2));
    assign idx0      = cnt_after[IDX_W-1:0];
    assign idx1      = idx0 + IDX_W'(1);

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (pop && (i < DEPTH - 1))
                q_next[i] = q_reg[(i + 1) % DEPTH];
            else
                q_next[i] = q_reg[i];
            if ((push.n != 2'd0) && (idx0 == IDX_W'(i)))
                q_next[i] = push.tok0;
            if ((push.n == 2'd2) && (idx1 == IDX_W'(i)))
                q_next[i] = push.tok1;
        end
        count_next = cnt_after + CNT_W'(push.n);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
            q_reg[i] <= q_next[i];
    end

endmodule

FILE: tb/keyword_number_tokenizer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for keyword_number_tokenizer_unit: feeds character streams,
// predicts every token in a scoreboard class and checks the m_ stream against it.
// Depends on knt_pkg and design/keyword_number_tokenizer_unit.sv.
module keyword_number_tokenizer_unit_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_CHARS  = 700;

    typedef struct {
        knt_pkg::kind_t kind;
        logic [11:0]    start;
        logic [11:0]    length;
        logic [7:0]     first;
        logic           last;
    } tok_rec_t;

    typedef enum {
        GRP_ALPHA, GRP_DIGIT, GRP_SPACE, GRP_OP, GRP_PUNCT, GRP_POINT, GRP_OTHER
    } char_grp_t;

    // Token predictor plus the queue of tokens still owed by the block.
    class token_board;
        string               kw_list [knt_pkg::KW_COUNT];
        tok_rec_t            expected [$];
        tok_rec_t            step_out [$];
        knt_pkg::scan_mode_t mode;
        logic                seen_point;
        logic [7:0]          prefix [knt_pkg::KEYWORD_MAX_LEN_DEF];
        logic [11:0]         column;
        logic [11:0]         tok_start;
        logic [11:0]         tok_len;
        logic [7:0]          tok_first;
        logic                halted;
        int                  errors;
        int                  checked;
        int                  kind_seen [7];

        function new();
            kw_list = '{"int", "float", "string", "bool", "char",
                        "if", "elif", "else", "branch",
                        "public", "private", "inherit", "package",
                        "nosign", "const", "extended",
                        "do", "while", "for", "repeat",
                        "in", "struct", "return"};
            mode       = knt_pkg::MODE_IDLE;
            seen_point = 1'b0;
            column     = '0;
            tok_start  = '0;
            tok_len    = '0;
            tok_first  = '0;
            halted     = 1'b0;
            errors     = 0;
            checked    = 0;
            foreach (prefix[i])
                prefix[i] = '0;
            foreach (kind_seen[i])
                kind_seen[i] = 0;
        endfunction

        function char_grp_t group_of(logic [7:0] c);
            if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A))
                return GRP_ALPHA;
            if (c >= 8'h30 && c <= 8'h39)
                return GRP_DIGIT;
            if (c == knt_pkg::CH_SPACE || c == knt_pkg::CH_TAB ||
                c == knt_pkg::CH_LF || c == knt_pkg::CH_CR)
                return GRP_SPACE;
            if (c == knt_pkg::CH_PLUS || c == knt_pkg::CH_MINUS ||
                c == knt_pkg::CH_STAR || c == knt_pkg::CH_SLASH)
                return GRP_OP;
            if (c == knt_pkg::CH_LPAREN || c == knt_pkg::CH_RPAREN ||
                c == knt_pkg::CH_LBRACE || c == knt_pkg::CH_RBRACE)
                return GRP_PUNCT;
            if (c == knt_pkg::CH_POINT)
                return GRP_POINT;
            return GRP_OTHER;
        endfunction

        // words longer than the stored prefix can never be keywords
        function bit is_keyword();
            bit same;
            if (tok_len > knt_pkg::KEYWORD_MAX_LEN_DEF)
                return 1'b0;
            foreach (kw_list[k])
            begin
                if (kw_list[k].len() == tok_len)
                begin
                    same = 1'b1;
                    for (int i = 0; i < kw_list[k].len(); i++)
                        if (kw_list[k][i] != prefix[i])
                            same = 1'b0;
                    if (same)
                        return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void emit(knt_pkg::kind_t k, logic [11:0] s, logic [11:0] n,
                           logic [7:0] f);
            tok_rec_t r;
            r.kind   = k;
            r.start  = s;
            r.length = n;
            r.first  = f;
            r.last   = 1'b0;
            step_out.push_back(r);
        endfunction

        function void close_token();
            knt_pkg::kind_t k;
            if (mode == knt_pkg::MODE_WORD)
                k = is_keyword() ? knt_pkg::KIND_KEYWORD : knt_pkg::KIND_IDENTIFIER;
            else if (mode == knt_pkg::MODE_NUM)
                k = seen_point ? knt_pkg::KIND_FLOAT : knt_pkg::KIND_INTEGER;
            else
                return;
            emit(k, tok_start, tok_len, tok_first);
            mode       = knt_pkg::MODE_IDLE;
            seen_point = 1'b0;
        endfunction

        // one accepted input transaction
        function void note_char(logic [7:0] c, logic le);
            char_grp_t   g;
            logic [11:0] col;
            bit          grows;
            if (halted)
                return;
            g   = group_of(c);
            col = column;
            step_out.delete();
            grows = (mode == knt_pkg::MODE_WORD && (g == GRP_ALPHA || g == GRP_DIGIT)) ||
                    (mode == knt_pkg::MODE_NUM &&
                     (g == GRP_DIGIT || (g == GRP_POINT && !seen_point)));
            if (grows)
            begin
                if (mode == knt_pkg::MODE_WORD && tok_len < knt_pkg::KEYWORD_MAX_LEN_DEF)
                    prefix[tok_len] = c;
                if (g == GRP_POINT)
                    seen_point = 1'b1;
                if (tok_len < knt_pkg::LEN_MAX)
                    tok_len++;
            end
            else
            begin
                close_token();
                case (g)
                    GRP_SPACE: ;
                    GRP_ALPHA, GRP_DIGIT:
                    begin
                        mode       = (g == GRP_ALPHA) ? knt_pkg::MODE_WORD :
                                                        knt_pkg::MODE_NUM;
                        seen_point = 1'b0;
                        tok_start  = col;
                        tok_len    = 12'd1;
                        tok_first  = c;
                        prefix[0]  = c;
                    end
                    GRP_OP:    emit(knt_pkg::KIND_OPERATOR, col, 12'd1, c);
                    GRP_PUNCT: emit(knt_pkg::KIND_PUNCT, col, 12'd1, c);
                    default:
                    begin
                        emit(knt_pkg::KIND_UNKNOWN, col, 12'd1, c);
                        halted = 1'b1;
                    end
                endcase
            end
            if (le)
                close_token();
            if (le)
                column = '0;
            else if (column < knt_pkg::COL_MAX)
                column++;
            if (step_out.size() > 0)
                step_out[step_out.size() - 1].last = 1'b1;
            foreach (step_out[i])
                expected.push_back(step_out[i]);
        endfunction

        task report_mismatch(input string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        // one output transaction
        task check_token(input logic [knt_pkg::TDATA_W-1:0] d, input logic last);
            tok_rec_t want;
            if (expected.size() == 0)
            begin
                report_mismatch($sformatf("token with nothing pending: data %h last %b",
                                          d, last));
                return;
            end
            want = expected.pop_front();
            checked++;
            if (d[2:0] !== want.kind || d[14:3] !== want.start || d[26:15] !== want.length ||
                d[34:27] !== want.first || last !== want.last)
                report_mismatch($sformatf(
                    "token %0d: got k%0d c%0d n%0d ch%h l%b, want k%0d c%0d n%0d ch%h l%b",
                    checked, d[2:0], d[14:3], d[26:15], d[34:27], last,
                    want.kind, want.start, want.length, want.first, want.last));
            else
                kind_seen[want.kind]++;
        endtask
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [7:0]                  s_tdata;
    logic                        s_tlast;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [knt_pkg::TDATA_W-1:0] m_tdata;
    logic                        m_tlast;

    token_board board = new();
    logic [7:0] pend [$];
    bit         gaps_on = 1'b1;
    int         chars_sent = 0;
    int         rand_sent = 0;
    int         cycle_count = 0;

    keyword_number_tokenizer_unit uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Run stopped at cycle %0d, %0d tokens still pending",
                     cycle_count, board.expected.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // sink side: random back-pressure, changed on the falling edge
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= !(gaps_on && $urandom_range(0, 99) < 29);
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_token(m_tdata, m_tlast);

    task automatic send_char(input logic [7:0] c, input logic le);
        while (gaps_on && $urandom_range(0, 99) < 29)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= le;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_char(c, le);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s, input bit end_line);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], end_line && (i == s.len() - 1));
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = 8'h61 + 8'($urandom_range(0, 25));
        if ($urandom_range(0, 1))
            c = c - 8'h20;      // upper case
        return c;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_alnum();
        return $urandom_range(0, 2) ? rand_letter() : rand_digit();
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            pend.push_back(s[i]);
    endfunction

    function automatic void add_word();
        string kw;
        kw = board.kw_list[$urandom_range(0, knt_pkg::KW_COUNT - 1)];
        case ($urandom_range(0, 3))
            0: add_text(kw);
            1:
            begin
                add_text(kw);
                repeat ($urandom_range(1, 3))
                    pend.push_back(rand_alnum());
            end
            2: add_text(kw.substr(0, kw.len() - 2));
            default:
            begin
                pend.push_back(rand_letter());
                repeat ($urandom_range(0, 9))
                    pend.push_back(rand_alnum());
            end
        endcase
    endfunction

    function automatic void add_number();
        repeat ($urandom_range(1, 6))
            pend.push_back(rand_digit());
        if ($urandom_range(0, 1))
        begin
            pend.push_back(knt_pkg::CH_POINT);
            repeat ($urandom_range(0, 4))
                pend.push_back(rand_digit());
        end
    endfunction

    function automatic void add_sep();
        logic [7:0] ops [4];
        logic [7:0] puncts [4];
        logic [7:0] blanks [4];
        ops    = '{knt_pkg::CH_PLUS, knt_pkg::CH_MINUS, knt_pkg::CH_STAR, knt_pkg::CH_SLASH};
        puncts = '{knt_pkg::CH_LPAREN, knt_pkg::CH_RPAREN,
                   knt_pkg::CH_LBRACE, knt_pkg::CH_RBRACE};
        blanks = '{knt_pkg::CH_SPACE, knt_pkg::CH_TAB, knt_pkg::CH_LF, knt_pkg::CH_CR};
        case ($urandom_range(0, 2))
            0: pend.push_back(ops[$urandom_range(0, 3)]);
            1: pend.push_back(puncts[$urandom_range(0, 3)]);
            default:
                repeat ($urandom_range(1, 2))
                    pend.push_back(blanks[$urandom_range(0, 3)]);
        endcase
    endfunction

    // Every group ends in a separator so a point never lands outside a number;
    // a line end is kept off the digit just before a point for the same reason.
    task automatic send_sentence();
        bit le;
        repeat ($urandom_range(1, 6))
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    add_word();
                    add_sep();
                end
                1:
                begin
                    add_number();
                    if ($urandom_range(0, 4) == 0)
                        add_word();
                    add_sep();
                end
                default: add_sep();
            endcase
        end
        foreach (pend[i])
        begin
            le = ($urandom_range(0, 11) == 0);
            if (i == pend.size() - 1 && $urandom_range(0, 2) == 0)
                le = 1'b1;
            if (i + 1 < pend.size() && pend[i + 1] == knt_pkg::CH_POINT)
                le = 1'b0;
            send_char(pend[i], le);
        end
        pend.delete();
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: keyword at full prefix length, operator after a word, float closed
        // by a letter, word closed by line end, all operators and punctuators, blanks
        send_text("extended+", 1'b0);
        send_text("0.9z", 1'b1);
        send_text("-/*(){}", 1'b1);
        send_text("A", 1'b0);
        send_char(knt_pkg::CH_CR, 1'b0);
        send_char(knt_pkg::CH_LF, 1'b0);
        send_char(knt_pkg::CH_TAB, 1'b0);
        send_char(knt_pkg::CH_SPACE, 1'b1);

        // random lines, with a stretch of full-rate traffic in the middle
        while (rand_sent < RAND_CHARS)
        begin
            gaps_on = !(rand_sent >= 300 && rand_sent < 500);
            rand_sent -= chars_sent;
            send_sentence();
            rand_sent += chars_sent;
        end
        gaps_on = 1'b1;

        // second point in a number: float, then unknown, then the block stays halted
        send_text("ab 3.14.", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h80, 1'b0);
        send_text("x1", 1'b1);
        s_tvalid <= 1'b0;

        while (board.expected.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);

        $display("Sent %0d characters (%0d random), %0d tokens checked",
                 chars_sent, rand_sent, board.checked);
        $display("Kinds: kw %0d id %0d int %0d float %0d op %0d punct %0d unknown %0d",
                 board.kind_seen[knt_pkg::KIND_KEYWORD],
                 board.kind_seen[knt_pkg::KIND_IDENTIFIER],
                 board.kind_seen[knt_pkg::KIND_INTEGER],
                 board.kind_seen[knt_pkg::KIND_FLOAT],
                 board.kind_seen[knt_pkg::KIND_OPERATOR],
                 board.kind_seen[knt_pkg::KIND_PUNCT],
                 board.kind_seen[knt_pkg::KIND_UNKNOWN]);
        if (board.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
